FILE: sv/rcu_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// rcu_pkg
// Shared types and constants of the rectangle clip unit.
// ============================================================================
package rcu_pkg;

    // Request operation codes
    typedef enum logic [2:0] {
        OP_NORMALIZE = 3'd0,
        OP_COVERED   = 3'd1,
        OP_INTERSECT = 3'd2,
        OP_UNION     = 3'd3,
        OP_BOUND     = 3'd4,
        OP_SUBTRACT  = 3'd5
    } t_op;

    localparam int MAX_PIECES  = 4;
    localparam int PIECE_IDX_W = 2;
    localparam int CNT_W       = 3;

    // Per-request status handed from the compute logic to the output buffer
    typedef struct packed {
        logic             flag;
        logic [CNT_W-1:0] count;
    } t_calc_ctl;

endpackage

FILE: sv/rcu_if.sv
`timescale 1ns / 1ps
// ============================================================================
// rcu_req_if / rcu_rsp_if
// Valid/ready channels carrying rectangle requests and result items.
// ============================================================================
interface rcu_req_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic [2:0]                    req_type;
    logic signed [COORD_WIDTH-1:0] a_left;
    logic signed [COORD_WIDTH-1:0] a_top;
    logic signed [COORD_WIDTH-1:0] a_right;
    logic signed [COORD_WIDTH-1:0] a_bottom;
    logic signed [COORD_WIDTH-1:0] b_left;
    logic signed [COORD_WIDTH-1:0] b_top;
    logic signed [COORD_WIDTH-1:0] b_right;
    logic signed [COORD_WIDTH-1:0] b_bottom;

    modport source (
        output valid, req_type, a_left, a_top, a_right, a_bottom,
               b_left, b_top, b_right, b_bottom,
        input  ready
    );
    modport sink (
        input  valid, req_type, a_left, a_top, a_right, a_bottom,
               b_left, b_top, b_right, b_bottom,
        output ready
    );
endinterface

interface rcu_rsp_if #(
    parameter int COORD_WIDTH = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] out_left;
    logic signed [COORD_WIDTH-1:0] out_top;
    logic signed [COORD_WIDTH-1:0] out_right;
    logic signed [COORD_WIDTH-1:0] out_bottom;
    logic                          flag;
    logic [2:0]                    piece_count;
    logic                          last;

    modport source (
        output valid, out_left, out_top, out_right, out_bottom, flag,
               piece_count, last,
        input  ready
    );
    modport sink (
        input  valid, out_left, out_top, out_right, out_bottom, flag,
               piece_count, last,
        output ready
    );
endinterface

FILE: sv/rcu_calc.sv
`timescale 1ns / 1ps
// ============================================================================
// rcu_calc
// Combinational rectangle operations; yields up to four packed result pieces.
// ============================================================================
module rcu_calc
    import rcu_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic [2:0]                                i_op,
    input  logic [4*COORD_WIDTH-1:0]                  i_a,
    input  logic [4*COORD_WIDTH-1:0]                  i_b,
    output logic [MAX_PIECES-1:0][4*COORD_WIDTH-1:0]  o_pieces,
    output t_calc_ctl                                 o_ctl
);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] l;
        logic signed [COORD_WIDTH-1:0] t;
        logic signed [COORD_WIDTH-1:0] r;
        logic signed [COORD_WIDTH-1:0] b;
    } t_rect;

    function automatic logic signed [COORD_WIDTH-1:0] f_max(
        input logic signed [COORD_WIDTH-1:0] x,
        input logic signed [COORD_WIDTH-1:0] y
    );
        return (x > y) ? x : y;
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] f_min(
        input logic signed [COORD_WIDTH-1:0] x,
        input logic signed [COORD_WIDTH-1:0] y
    );
        return (x < y) ? x : y;
    endfunction

    function automatic t_rect f_norm(input t_rect x);
        t_rect y;
        y = x;
        if (x.l > x.r) begin
            y.l = x.r;
            y.r = x.l;
        end
        if (x.t > x.b) begin
            y.t = x.b;
            y.b = x.t;
        end
        return y;
    endfunction

    t_rect a, b, p, q, res, zero;
    t_rect cand [MAX_PIECES];
    logic [MAX_PIECES-1:0] cand_en;
    logic signed [COORD_WIDTH-1:0] s_top, s_bot;
    logic hit;

    assign a    = i_a;
    assign b    = i_b;
    assign p    = f_norm(i_a);
    assign q    = f_norm(i_b);
    assign zero = '0;

    // Subtract pieces: top, bottom, left, right; side strips span the
    // band left after the top and bottom strips are cut off.
    assign hit = (f_max(a.l, b.l) < f_min(a.r, b.r)) &&
                 (f_max(a.t, b.t) < f_min(a.b, b.b));
    assign s_top = f_max(a.t, b.t);
    assign s_bot = f_min(a.b, b.b);

    always_comb begin
        cand[0] = '{l: a.l, t: a.t,   r: a.r, b: b.t};
        cand[1] = '{l: a.l, t: b.b,   r: a.r, b: a.b};
        cand[2] = '{l: a.l, t: s_top, r: b.l, b: s_bot};
        cand[3] = '{l: b.r, t: s_top, r: a.r, b: s_bot};
        cand_en = {b.r < a.r, b.l > a.l, b.b < a.b, b.t > a.t};
    end

    always_comb begin
        logic [CNT_W-1:0] n;
        n          = '0;
        res        = zero;
        o_ctl      = '{flag: 1'b0, count: CNT_W'(1)};
        o_pieces   = '0;

        unique case (t_op'(i_op))
            OP_NORMALIZE: begin
                res = p;
            end
            OP_COVERED: begin
                o_ctl.flag = !(a.l < b.l || a.t < b.t || a.r > b.r || a.b > b.b);
            end
            OP_INTERSECT: begin
                res.l = f_max(a.l, b.l);
                res.t = f_max(a.t, b.t);
                res.r = f_min(a.r, b.r);
                res.b = f_min(a.b, b.b);
                o_ctl.flag = (res.l < res.r) && (res.t < res.b);
            end
            OP_UNION: begin
                if (p.l == q.l && p.r == q.r) begin
                    if (p.t <= q.t && q.t <= p.b) begin
                        res = '{l: p.l, t: p.t, r: p.r, b: f_max(p.b, q.b)};
                        o_ctl.flag = 1'b1;
                    end else if (p.t >= q.t && q.b >= p.t) begin
                        res = '{l: p.l, t: q.t, r: p.r, b: f_max(p.b, q.b)};
                        o_ctl.flag = 1'b1;
                    end
                end else if (p.t == q.t && p.b == q.b) begin
                    if (p.l <= q.l && q.l <= p.r) begin
                        res = '{l: p.l, t: p.t, r: f_max(p.r, q.r), b: p.b};
                        o_ctl.flag = 1'b1;
                    end else if (p.l >= q.l && q.r >= p.l) begin
                        res = '{l: q.l, t: p.t, r: f_max(p.r, q.r), b: p.b};
                        o_ctl.flag = 1'b1;
                    end
                end
            end
            OP_BOUND: begin
                if (p.l == p.r || p.t == p.b) begin
                    res = q;
                end else if (q.l == q.r || q.t == q.b) begin
                    res = p;
                end else begin
                    res.l = f_min(p.l, q.l);
                    res.t = f_min(p.t, q.t);
                    res.r = f_max(p.r, q.r);
                    res.b = f_max(p.b, q.b);
                end
            end
            OP_SUBTRACT: begin
                if (!hit) begin
                    res = a;
                    n   = CNT_W'(1);
                end else begin
                    // pack existing pieces into consecutive slots
                    for (int k = 0; k < MAX_PIECES; k++) begin
                        if (cand_en[k]) begin
                            o_pieces[n[PIECE_IDX_W-1:0]] = cand[k];
                            n = n + CNT_W'(1);
                        end
                    end
                    res = o_pieces[0];
                end
                o_ctl.count = n;
            end
            default: begin
                res = zero;
            end
        endcase

        // slot 0 carries the single result; it is zero when nothing remains
        o_pieces[0] = res;
    end

endmodule

FILE: sv/rcu_emit.sv
`timescale 1ns / 1ps
// ============================================================================
// rcu_emit
// Result buffer: holds a request's pieces, hands out one per cycle on i_ready.
// ============================================================================
module rcu_emit
    import rcu_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_load,
    input  logic [MAX_PIECES-1:0][4*COORD_WIDTH-1:0]  i_pieces,
    input  t_calc_ctl                                 i_ctl,
    input  logic                                      i_ready,
    output logic                                      o_valid,
    output logic                                      o_free,
    output logic [4*COORD_WIDTH-1:0]                  o_rect,
    output t_calc_ctl                                 o_ctl,
    output logic                                      o_last
);

    logic                                     r_valid, n_valid;
    logic [PIECE_IDX_W-1:0]                   r_idx, n_idx;
    logic [PIECE_IDX_W-1:0]                   r_last_idx;
    logic [MAX_PIECES-1:0][4*COORD_WIDTH-1:0] r_pieces;
    t_calc_ctl                                r_ctl;
    logic                                     take;

    assign o_valid = r_valid;
    assign o_last  = (r_idx == r_last_idx);
    assign o_rect  = r_pieces[r_idx];
    assign o_ctl   = r_ctl;
    assign take    = r_valid && i_ready;
    // buffer can be refilled when empty or its final item leaves now
    assign o_free  = !r_valid || (take && o_last);

    always_comb begin
        n_valid = r_valid;
        n_idx   = r_idx;
        if (i_load) begin
            n_valid = 1'b1;
            n_idx   = '0;
        end else if (take) begin
            if (o_last) begin
                n_valid = 1'b0;
            end else begin
                n_idx = r_idx + PIECE_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pieces   <= i_pieces;
            r_ctl      <= i_ctl;
            r_last_idx <= (i_ctl.count == '0) ? '0
                        : PIECE_IDX_W'(i_ctl.count - CNT_W'(1));
        end
    end

endmodule

FILE: sv/rectangle_clip_unit.sv
`timescale 1ns / 1ps
// ============================================================================
// rectangle_clip_unit
// Normalize, covered test, intersect, union, bound and subtract of rectangles.
// ============================================================================
// Usage:
//  - i_req takes one request item per valid/ready handshake: an operation
//    code and rectangles A and B (right and bottom exclusive, signed).
//  - o_rsp returns result items. Every operation gives one item with
//    piece_count 1, except subtract, which gives one item per remaining
//    piece (top, bottom, left, right order) all carrying the same count,
//    or a single zero item with count 0 when nothing remains. last marks
//    the final item of a request.
//  - Path: a request accepted at i_req goes into the input register, then
//    into the result buffer, which presents its result items on o_rsp.
//  - Flow: the result buffer drains one item per cycle while the receiver
//    is ready, and takes the next request as its final item leaves.
//  - i_req.ready stays high while a finished result waits, as long as the
//    input register is free; a stalled receiver fills the input register
//    and then holds ready low. Nothing is lost or repeated under stalls.
//  - Synchronous active-low reset empties both stages; payload registers
//    are not cleared.
// ============================================================================
module rectangle_clip_unit
    import rcu_pkg::*;
#(
    parameter int COORD_WIDTH = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    rcu_req_if.sink   i_req,
    rcu_rsp_if.source o_rsp
);

    // ---------------- input register ----------------
    logic                     r_in_valid, n_in_valid;
    logic [2:0]               r_op;
    logic [4*COORD_WIDTH-1:0] r_a, r_b;
    logic                     in_take;
    logic                     load;

    // ---------------- compute / buffer wiring ----------------
    logic [MAX_PIECES-1:0][4*COORD_WIDTH-1:0] calc_pieces;
    t_calc_ctl                                calc_ctl;
    t_calc_ctl                                emit_ctl;
    logic                                     emit_free;
    logic [4*COORD_WIDTH-1:0]                 emit_rect;

    // Request moves to the buffer when the buffer can take it this cycle.
    assign load        = r_in_valid && emit_free;
    assign i_req.ready = !r_in_valid || emit_free;
    assign in_take     = i_req.valid && i_req.ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (load) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_op <= i_req.req_type;
            r_a  <= {i_req.a_left, i_req.a_top, i_req.a_right, i_req.a_bottom};
            r_b  <= {i_req.b_left, i_req.b_top, i_req.b_right, i_req.b_bottom};
        end
    end

    rcu_calc #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_calc (
        .i_op     (r_op),
        .i_a      (r_a),
        .i_b      (r_b),
        .o_pieces (calc_pieces),
        .o_ctl    (calc_ctl)
    );

    rcu_emit #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (load),
        .i_pieces (calc_pieces),
        .i_ctl    (calc_ctl),
        .i_ready  (o_rsp.ready),
        .o_valid  (o_rsp.valid),
        .o_free   (emit_free),
        .o_rect   (emit_rect),
        .o_ctl    (emit_ctl),
        .o_last   (o_rsp.last)
    );

    // Rectangle packed as {left, top, right, bottom}
    assign o_rsp.out_left    = emit_rect[4*COORD_WIDTH-1:3*COORD_WIDTH];
    assign o_rsp.out_top     = emit_rect[3*COORD_WIDTH-1:2*COORD_WIDTH];
    assign o_rsp.out_right   = emit_rect[2*COORD_WIDTH-1:COORD_WIDTH];
    assign o_rsp.out_bottom  = emit_rect[COORD_WIDTH-1:0];
    assign o_rsp.flag        = emit_ctl.flag;
    assign o_rsp.piece_count = emit_ctl.count;

endmodule
